// ===== sv/msxsb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the sound bus decoder.
package msxsb_pkg;

    localparam int SONG_SLOTS       = 16;
    localparam int SKIP_PORT_NUMBER = 255;
    localparam int SHADOW_DEPTH     = 256;

    // Bus access codes
    localparam logic [2:0] CMD_IO_RD  = 3'd0;
    localparam logic [2:0] CMD_IO_WR  = 3'd1;
    localparam logic [2:0] CMD_MEM_RD = 3'd2;
    localparam logic [2:0] CMD_MEM_WR = 3'd3;
    localparam logic [2:0] CMD_ARM    = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_GENERIC_MODE = 3'd0;
    localparam logic [2:0] CFG_WAVE_ENABLE  = 3'd1;
    localparam logic [2:0] CFG_FM_PRESENT   = 3'd2;
    localparam logic [2:0] CFG_BANK_OFFSET  = 3'd3;
    localparam logic [2:0] CFG_BANK_COUNT   = 3'd4;
    localparam logic [2:0] CFG_BANK_IS_8K   = 3'd5;
    localparam logic [2:0] CFG_TITLE_VALUE  = 3'd6;
    localparam logic [2:0] CFG_SONG_MASK    = 3'd7;

    // I/O ports
    localparam logic [7:0] PORT_SONG    = 8'h00;
    localparam logic [7:0] PORT_PLAY    = 8'h02;
    localparam logic [7:0] PORT_TITLE   = 8'h04;
    localparam logic [7:0] PORT_FM0_LAT = 8'h7c;
    localparam logic [7:0] PORT_FM0_DAT = 8'h7d;
    localparam logic [7:0] PORT_FM1_LAT = 8'hc0;
    localparam logic [7:0] PORT_FM1_DAT = 8'hc1;
    localparam logic [7:0] PORT_FM2_LAT = 8'hf0;
    localparam logic [7:0] PORT_FM2_DAT = 8'hf1;
    localparam logic [7:0] PORT_PSG_LAT = 8'ha0;
    localparam logic [7:0] PORT_PSG_WR  = 8'ha1;
    localparam logic [7:0] PORT_PSG_RD  = 8'ha2;
    localparam logic [7:0] PORT_BANK16  = 8'hfe;
    localparam logic [7:0] PORT_SKIP    = 8'(SKIP_PORT_NUMBER);

    // Memory map
    localparam logic [15:0] ADDR_FM_LAT   = 16'h7ff4;
    localparam logic [15:0] ADDR_FM_DAT   = 16'h7ff5;
    localparam logic [15:0] ADDR_MAPPER_A = 16'h9000;
    localparam logic [15:0] ADDR_MAPPER_B = 16'hb000;
    localparam logic [15:0] WAVE_MASK     = 16'hdfff;
    localparam logic [15:0] WAVE_XOR      = 16'h9800;
    localparam logic [15:0] WAVE_SPAN     = 16'h0090;
    localparam logic [15:0] WIN_BASE_A    = 16'h8000;
    localparam logic [15:0] WIN_BASE_B    = 16'ha000;
    localparam logic [7:0]  MAP_LOW_BITS  = 8'h3f;
    localparam logic [7:0]  MAP_ENABLE    = 8'h80;

    localparam logic [7:0] SONG_SLOTS_B  = 8'(SONG_SLOTS);
    localparam logic [3:0] PLAY_ARM_CNT  = 4'd8;

    typedef enum logic [3:0] {
        RT_NONE    = 4'd0,
        RT_RAM_WR  = 4'd1,
        RT_RAM_RD  = 4'd2,
        RT_PSG_WR  = 4'd3,
        RT_PSG_RD  = 4'd4,
        RT_FM_WR   = 4'd5,
        RT_WAVE_WR = 4'd6,
        RT_BANK    = 4'd7,
        RT_STAGE   = 4'd8,
        RT_PORT    = 4'd9
    } t_route;

    typedef struct packed {
        logic        generic_mode;
        logic        wave_enable;
        logic        fm_present;
        logic [7:0]  bank_offset;
        logic [6:0]  bank_count;
        logic        bank_is_8k;
        logic [7:0]  title_value;
        logic [15:0] song_present_mask;
    } t_cfg;

    typedef struct packed {
        logic [7:0] fm_latch;
        logic       wave_mapped;
        logic [3:0] play_pending;
        logic       idle_flag;
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] address;
        logic [7:0]  data;
    } t_item;

    typedef struct packed {
        t_route      route;
        logic [15:0] target_addr;
        logic [7:0]  target_data;
        logic        window_is_8k;
        logic [7:0]  read_data;
        logic        idle;
    } t_res;

endpackage

// ===== sv/msxsb_in_if.sv =====
`timescale 1ns / 1ps
// Bus access channel interface.
interface msxsb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] address;
    logic [7:0]  data;

    modport source (output valid, output cmd, output address, output data, input ready);
    modport sink   (input valid, input cmd, input address, input data, output ready);
endinterface

// ===== sv/msxsb_out_if.sv =====
`timescale 1ns / 1ps
// Routed command channel interface.
interface msxsb_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  route;
    logic [15:0] target_addr;
    logic [7:0]  target_data;
    logic        window_is_8k;
    logic [7:0]  read_data;
    logic        idle;

    modport source (output valid, output route, output target_addr, output target_data,
                    output window_is_8k, output read_data, output idle, input ready);
    modport sink   (input valid, input route, input target_addr, input target_data,
                    input window_is_8k, input read_data, input idle, output ready);
endinterface

// ===== sv/msxsb_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel interface.
interface msxsb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== sv/msxsb_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module msxsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/msxsb_decode.sv =====
`timescale 1ns / 1ps
// Access decoder: routes one bus access and computes the next control state.
module msxsb_decode (
    input  msxsb_pkg::t_item  i_item,
    input  msxsb_pkg::t_cfg   i_cfg,
    input  msxsb_pkg::t_state i_state,
    input  logic [7:0]        i_shadow,
    output msxsb_pkg::t_res   o_res,
    output msxsb_pkg::t_state o_state
);
    import msxsb_pkg::*;

    logic [7:0]  p;
    logic [7:0]  d;
    logic [15:0] a;
    logic [8:0]  diff;
    logic        bank_ok;
    logic [15:0] w;
    logic        fm_port;
    logic        wave_hit;
    t_res        res;
    t_state      nxt;

    always_comb begin
        p        = i_item.address[7:0];
        d        = i_item.data;
        a        = i_item.address;
        nxt      = i_state;
        res      = '0;
        res.route = RT_NONE;
        wave_hit = 1'b0;

        // bank number relative to the image's first bank
        diff    = {1'b0, d} - {1'b0, i_cfg.bank_offset};
        bank_ok = (i_cfg.bank_count != 7'd0) && !diff[8]
                  && (diff[7:0] < {1'b0, i_cfg.bank_count});
        w       = (a & WAVE_MASK) ^ WAVE_XOR;
        fm_port = (p == PORT_FM0_LAT) || (p == PORT_FM0_DAT) || (p == PORT_FM1_LAT)
                  || (p == PORT_FM1_DAT) || (p == PORT_FM2_LAT) || (p == PORT_FM2_DAT);

        unique case (i_item.cmd)
            CMD_IO_RD: begin
                priority if (p == PORT_SKIP) begin
                    nxt.idle_flag = 1'b1;
                    res.route     = RT_PORT;
                end else if (i_cfg.generic_mode && p == PORT_PLAY) begin
                    res.route = RT_PORT;
                    if (i_state.play_pending != 4'd0) begin
                        nxt.play_pending = i_state.play_pending - 4'd1;
                        res.read_data    = 8'd1;
                    end
                end else if (i_cfg.generic_mode && p == PORT_TITLE) begin
                    res.route     = RT_PORT;
                    res.read_data = i_cfg.title_value;
                end else if (p == PORT_PSG_LAT || p == PORT_PSG_WR || p == PORT_PSG_RD) begin
                    res.route       = RT_PSG_RD;
                    res.target_addr = {15'd0, p[0]};
                end else begin
                    res.route     = RT_PORT;
                    res.read_data = i_shadow;
                end
            end
            CMD_IO_WR: begin
                if (fm_port) begin
                    if (i_cfg.generic_mode || i_cfg.fm_present) begin
                        if (!p[0]) begin
                            nxt.fm_latch = d;
                        end else begin
                            res.route       = RT_FM_WR;
                            res.target_addr = {8'd0, i_state.fm_latch};
                            res.target_data = d;
                        end
                    end
                end else if (p == PORT_PSG_LAT || p == PORT_PSG_WR) begin
                    res.route       = RT_PSG_WR;
                    res.target_addr = {15'd0, p[0]};
                    res.target_data = d;
                end else if (p == PORT_BANK16) begin
                    if (!i_cfg.bank_is_8k && bank_ok) begin
                        res.route       = RT_BANK;
                        res.target_addr = WIN_BASE_A;
                        res.target_data = diff[7:0];
                    end
                end else if (i_cfg.generic_mode && p == PORT_SONG && d < SONG_SLOTS_B
                             && i_cfg.song_present_mask[d[3:0]]) begin
                    res.route       = RT_STAGE;
                    res.target_data = d;
                end
            end
            CMD_MEM_RD: begin
                res.route       = RT_RAM_RD;
                res.target_addr = a;
            end
            CMD_MEM_WR: begin
                if (i_cfg.generic_mode && (a == ADDR_FM_LAT || a == ADDR_FM_DAT)) begin
                    if (a == ADDR_FM_LAT) begin
                        nxt.fm_latch = d;
                    end else begin
                        res.route       = RT_FM_WR;
                        res.target_addr = {8'd0, i_state.fm_latch};
                        res.target_data = d;
                    end
                end else begin
                    if (a == ADDR_MAPPER_A) begin
                        nxt.wave_mapped = ((d & MAP_LOW_BITS) == MAP_LOW_BITS);
                    end else if (a == ADDR_MAPPER_B) begin
                        if (d == MAP_ENABLE || (d & MAP_LOW_BITS) == MAP_LOW_BITS) begin
                            nxt.wave_mapped = 1'b1;
                        end
                    end else if ((i_cfg.wave_enable || i_state.wave_mapped)
                                 && w < WAVE_SPAN) begin
                        wave_hit        = 1'b1;
                        res.route       = RT_WAVE_WR;
                        res.target_addr = w;
                        res.target_data = d;
                    end
                    if (!wave_hit) begin
                        if (i_cfg.bank_is_8k && i_cfg.bank_count != 7'd0
                            && (a == ADDR_MAPPER_A || a == ADDR_MAPPER_B)) begin
                            if (bank_ok) begin
                                res.route        = RT_BANK;
                                res.target_addr  = (a == ADDR_MAPPER_A) ? WIN_BASE_A
                                                                        : WIN_BASE_B;
                                res.target_data  = diff[7:0];
                                res.window_is_8k = 1'b1;
                            end
                        end else begin
                            res.route       = RT_RAM_WR;
                            res.target_addr = a;
                            res.target_data = d;
                        end
                    end
                end
            end
            CMD_ARM: begin
                nxt.play_pending = PLAY_ARM_CNT;
                nxt.idle_flag    = 1'b0;
            end
            default: begin
                res.route = RT_NONE;
            end
        endcase

        res.idle = nxt.idle_flag;
        o_res    = res;
        o_state  = nxt;
    end
endmodule

// ===== sv/msx_sound_bus_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the sound bus decoder: shadow RAM, decode stage and result register.
//
// Takes one bus access item per cycle unless the output stalls and returns one
// routed command item per access, in order; throughput is one item per clock
// when unstalled. The decode stage gets the item with the registered read of the
// 256 x 8 port shadow RAM (I/O writes store there at accept, I/O reads fetch there
// at accept, so one port per cycle suffices and no forwarding is needed), then
// evaluates it against the control registers (FM latch, mapper gate, play
// mailbox, idle flag) and loads the output register; a full output register
// stalls only when the sink holds ready low. Port shadow entries read as zero until
// first written, tracked by one valid bit per port, so there is no clearing pass
// after reset. Configuration writes are always taken and only meant while idle.
module msx_sound_bus_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    msxsb_in_if.sink           i_item,
    msxsb_out_if.source        o_res,
    msxsb_cfg_if.sink          i_cfg
);
    import msxsb_pkg::*;

    localparam int SH_AW = $clog2(SHADOW_DEPTH);

    t_cfg     r_cfg,     n_cfg;
    t_state   r_state;
    t_state   dec_state;
    t_res     dec_res;
    t_res     r_out;
    logic     r_out_vld;
    t_item    r_s1_item;
    logic     r_s1_vld;
    logic     r_s1_shvld;
    logic [SHADOW_DEPTH-1:0] r_sh_vld;

    logic       out_free;
    logic       s1_adv;
    logic       acc;
    logic       sh_we;
    logic [7:0] sh_rdata;
    logic [7:0] sh_byte;
    logic [SH_AW-1:0] port;

    // handshake
    assign out_free     = !r_out_vld || o_res.ready;
    assign s1_adv       = r_s1_vld && out_free;
    assign i_item.ready = !r_s1_vld || s1_adv;
    assign acc          = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    assign port  = i_item.address[SH_AW-1:0];
    assign sh_we = acc && (i_item.cmd == CMD_IO_WR);

    // port shadow: written by I/O writes, read for every accepted item
    msxsb_ram #(
        .WIDTH (8),
        .DEPTH (SHADOW_DEPTH)
    ) u_shadow (
        .i_clk   (i_clk),
        .i_we    (sh_we),
        .i_waddr (port),
        .i_wdata (i_item.data),
        .i_re    (acc),
        .i_raddr (port),
        .o_rdata (sh_rdata)
    );

    // RAM data holds while the item waits, since reads only happen at accept
    assign sh_byte = r_s1_shvld ? sh_rdata : 8'd0;

    msxsb_decode u_decode (
        .i_item   (r_s1_item),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_shadow (sh_byte),
        .o_res    (dec_res),
        .o_state  (dec_state)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_GENERIC_MODE: n_cfg.generic_mode      = i_cfg.wdata[0];
                CFG_WAVE_ENABLE:  n_cfg.wave_enable       = i_cfg.wdata[0];
                CFG_FM_PRESENT:   n_cfg.fm_present        = i_cfg.wdata[0];
                CFG_BANK_OFFSET:  n_cfg.bank_offset       = i_cfg.wdata[7:0];
                CFG_BANK_COUNT:   n_cfg.bank_count        = i_cfg.wdata[6:0];
                CFG_BANK_IS_8K:   n_cfg.bank_is_8k        = i_cfg.wdata[0];
                CFG_TITLE_VALUE:  n_cfg.title_value       = i_cfg.wdata[7:0];
                CFG_SONG_MASK:    n_cfg.song_present_mask = i_cfg.wdata;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '0;
            r_state   <= '0;
            r_sh_vld  <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
            if (sh_we) begin
                r_sh_vld[port] <= 1'b1;
            end
            if (s1_adv) begin
                r_state <= dec_state;
            end
            if (i_item.ready) begin
                r_s1_vld <= i_item.valid;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_item  <= '{cmd: i_item.cmd, address: i_item.address, data: i_item.data};
            r_s1_shvld <= r_sh_vld[port];
        end
        if (s1_adv) begin
            r_out <= dec_res;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.route        = r_out.route;
    assign o_res.target_addr  = r_out.target_addr;
    assign o_res.target_data  = r_out.target_data;
    assign o_res.window_is_8k = r_out.window_is_8k;
    assign o_res.read_data    = r_out.read_data;
    assign o_res.idle         = r_out.idle;
endmodule
